// ===== rtl/spod_pkg.sv =====
// Shared types and codes for the shortest path with one halved edge block.
`default_nettype none
package spod_pkg;

  localparam int unsigned FIELD_NODE_W = 11;
  localparam int unsigned FIELD_WGT_W  = 32;
  localparam int unsigned FIELD_COST_W = 48;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_CLEAR = 2'd2
  } spod_action_e;

  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_START_NODE = 1'b1
  } spod_cfg_e;

  typedef enum logic [4:0] {
    S_HCLR,
    S_IDLE,
    S_LD,
    S_DCLR,
    S_POP0,
    S_POP1,
    S_POP2,
    S_SD0,
    S_SD1,
    S_SD2,
    S_SD3,
    S_CHK,
    S_CHK1,
    S_HEAD,
    S_EW,
    S_ER,
    S_RX0,
    S_RX1,
    S_RXN,
    S_SU0,
    S_SU1,
    S_FIN0,
    S_FIN1,
    S_FIN2,
    S_EMIT
  } spod_state_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [FIELD_NODE_W-1:0] edge_from;
    logic [FIELD_NODE_W-1:0] edge_to;
    logic [FIELD_WGT_W-1:0]  edge_weight;
  } spod_in_t;

  typedef struct packed {
    logic [FIELD_COST_W-1:0] best_cost;
    logic                    reachable;
    logic                    edges_full;
  } spod_out_t;

endpackage
`default_nettype wire

// ===== rtl/spod_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module spod_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/shortest_path_one_half_discount.sv =====
// Edge loads write the edge store and a list head; clear sweeps the list heads to empty; a run
// first clears the 2n distance entries, then works through heap pop levels, edges and relax steps.
// Each memory has one registered read port, which sets the pace.
// One request is in work at a time; the next is taken while a result waits.
// After reset the node list heads are swept to empty, with no request taken meanwhile.
`default_nettype none
module shortest_path_one_half_discount
  import spod_pkg::*;
#(
  parameter int unsigned MAX_NODES  = 1024,
  parameter int unsigned MAX_EDGES  = 4096,
  parameter int unsigned COST_WIDTH = 48
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire spod_in_t                in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output spod_out_t                    out_data_o,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [FIELD_NODE_W-1:0] cfg_data_i
);

  localparam int unsigned NIW   = $clog2(MAX_NODES);
  localparam int unsigned NW    = $clog2(MAX_NODES + 1);
  localparam int unsigned DAW   = NIW + 1;
  localparam int unsigned EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned LW    = $clog2(MAX_EDGES + 1);
  localparam int unsigned HDEP  = 3 * MAX_EDGES + 1;
  localparam int unsigned HAW   = $clog2(HDEP);
  localparam int unsigned HSW   = $clog2(HDEP + 1);
  localparam int unsigned HEW   = COST_WIDTH + NIW + 1;
  localparam int unsigned EDW   = NIW + FIELD_WGT_W + LW;
  localparam int unsigned SUMW  = ((COST_WIDTH > FIELD_WGT_W) ? COST_WIDTH : FIELD_WGT_W) + 1;
  localparam logic [COST_WIDTH-1:0] COST_MAX = {COST_WIDTH{1'b1}};
  localparam logic [LW-1:0] EMPTY_LINK = LW'(MAX_EDGES);

  spod_state_e state_q, state_d;

  logic [DAW-1:0]          cnt_q, cnt_d;
  logic [LW-1:0]           edge_cnt_q, edge_cnt_d;
  logic [HSW-1:0]          heap_size_q, heap_size_d;
  logic [FIELD_NODE_W-1:0] node_cnt_q, node_cnt_d, start_q, start_d;
  logic                    out_valid_q, out_valid_d;

  logic [NW-1:0]           n_q, n_d;
  logic [NIW-1:0]          s_q, s_d;
  logic [NIW-1:0]          ld_from_q, ld_from_d, ld_to_q, ld_to_d;
  logic [FIELD_WGT_W-1:0]  ld_w_q, ld_w_d;
  logic [COST_WIDTH-1:0]   cur_cost_q, cur_cost_d;
  logic [NIW-1:0]          cur_node_q, cur_node_d;
  logic                    cur_cp_q, cur_cp_d;
  logic [LW-1:0]           e_q, e_d;
  logic [NIW-1:0]          t_q, t_d;
  logic [FIELD_WGT_W-1:0]  w_q, w_d;
  logic [COST_WIDTH-1:0]   rx_cost_q, rx_cost_d;
  logic [NIW-1:0]          rx_node_q, rx_node_d;
  logic                    rx_cp_q, rx_cp_d;
  logic                    sec_q, sec_d;
  logic [HSW-1:0]          hi_q, hi_d, ci_q, ci_d;
  logic [HEW-1:0]          ent_q, ent_d, child_q, child_d;
  logic [COST_WIDTH-1:0]   best_q, best_d;
  spod_out_t               res_q, res_d, out_q, out_d;

  // memory ports
  logic             head_we, dist_we, edge_we, heap_we;
  logic [NIW-1:0]   head_waddr, head_raddr;
  logic [LW-1:0]    head_wdata, head_rdata;
  logic [DAW-1:0]   dist_waddr, dist_raddr;
  logic [COST_WIDTH-1:0] dist_wdata, dist_rdata;
  logic [EAW-1:0]   edge_waddr, edge_raddr;
  logic [EDW-1:0]   edge_wdata, edge_rdata;
  logic [HAW-1:0]   heap_waddr, heap_raddr;
  logic [HEW-1:0]   heap_wdata, heap_rdata;

  spod_ram #(.DEPTH(MAX_NODES), .WIDTH(LW)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );
  spod_ram #(.DEPTH(2 * MAX_NODES), .WIDTH(COST_WIDTH)) u_dist (
    .clk_i, .we_i(dist_we), .waddr_i(dist_waddr), .wdata_i(dist_wdata),
    .raddr_i(dist_raddr), .rdata_o(dist_rdata)
  );
  spod_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDW)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );
  spod_ram #(.DEPTH(HDEP), .WIDTH(HEW)) u_heap (
    .clk_i, .we_i(heap_we), .waddr_i(heap_waddr), .wdata_i(heap_wdata),
    .raddr_i(heap_raddr), .rdata_o(heap_rdata)
  );

  // request decode
  logic        acc;
  logic [31:0] from_m1, to_m1, start_m1, n_clamp;
  logic        ld_bad, ld_full, run_bad;
  assign acc      = in_valid_i && (state_q == S_IDLE);
  assign from_m1  = 32'(in_data_i.edge_from) - 32'd1;
  assign to_m1    = 32'(in_data_i.edge_to) - 32'd1;
  assign start_m1 = 32'(start_q) - 32'd1;
  assign ld_bad   = (in_data_i.edge_from == '0) || (32'(in_data_i.edge_from) > MAX_NODES) ||
                    (in_data_i.edge_to == '0) || (32'(in_data_i.edge_to) > MAX_NODES);
  assign ld_full  = (32'(edge_cnt_q) >= MAX_EDGES);
  assign n_clamp  = (node_cnt_q == '0) ? 32'd1 :
                    ((32'(node_cnt_q) > MAX_NODES) ? 32'(MAX_NODES) : 32'(node_cnt_q));
  assign run_bad  = (start_q == '0) || (32'(start_q) > n_clamp);

  // search conditions
  logic [NIW-1:0]  dest;
  logic [HSW:0]    c_idx, c1_idx;
  logic [HSW-1:0]  p_idx;
  logic [NIW-1:0]  er_t;
  logic [FIELD_WGT_W-1:0] er_w;
  logic [LW-1:0]   er_next;
  logic [COST_WIDTH-1:0] heap_rd_cost, ent_cost, child_cost;
  logic            hclr_last, dclr_last, sd_leaf, sd_has_b, sd3_stop, chk_dest, chk1_stale;
  logic            ew_more, er_in, rx_better, heap_full, su_root, su1_stop, emit_ok;
  logic [DAW-1:0]  dclr_end;

  assign dest         = NIW'(n_q - NW'(1));
  assign c_idx        = {hi_q, 1'b1};
  assign c1_idx       = c_idx + (HSW+1)'(1);
  assign p_idx        = (hi_q - HSW'(1)) >> 1;
  assign er_t         = edge_rdata[EDW-1 -: NIW];
  assign er_w         = edge_rdata[LW +: FIELD_WGT_W];
  assign er_next      = edge_rdata[LW-1:0];
  assign heap_rd_cost = heap_rdata[HEW-1 -: COST_WIDTH];
  assign ent_cost     = ent_q[HEW-1 -: COST_WIDTH];
  assign child_cost   = child_q[HEW-1 -: COST_WIDTH];
  assign hclr_last    = (cnt_q == DAW'(MAX_NODES - 1));
  assign dclr_end     = DAW'({n_q, 1'b0} - (NW+1)'(1));
  assign dclr_last    = (cnt_q == dclr_end);
  assign sd_leaf      = (c_idx >= {1'b0, heap_size_q});
  assign sd_has_b     = (c1_idx < {1'b0, heap_size_q});
  assign sd3_stop     = (ent_cost <= child_cost);
  assign chk_dest     = (cur_node_q == dest);
  assign chk1_stale   = (dist_rdata < cur_cost_q);
  assign ew_more      = (e_q < edge_cnt_q);
  assign er_in        = (NW'(er_t) < n_q);
  assign rx_better    = (rx_cost_q < dist_rdata);
  assign heap_full    = (32'(heap_size_q) >= HDEP);
  assign su_root      = (hi_q == '0);
  assign su1_stop     = (heap_rd_cost <= ent_cost);
  assign emit_ok      = !out_valid_q || !out_stall_i;

  // shared saturating adder
  logic [FIELD_WGT_W-1:0] add_b;
  logic [SUMW-1:0]        add_sum;
  logic [COST_WIDTH-1:0]  add_sat;
  assign add_b   = (state_q == S_ER) ? er_w : (w_q >> 1);
  assign add_sum = SUMW'(cur_cost_q) + SUMW'(add_b);
  assign add_sat = (add_sum > SUMW'(COST_MAX)) ? COST_MAX : add_sum[COST_WIDTH-1:0];

  logic [COST_WIDTH-1:0] fin_best;
  logic [63:0]           fin_wide;
  assign fin_best = (dist_rdata < best_q) ? dist_rdata : best_q;
  assign fin_wide = 64'(fin_best);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_HCLR: if (hclr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          case (in_data_i.action)
            ACT_LOAD:  state_d = ld_bad ? S_IDLE : (ld_full ? S_EMIT : S_LD);
            ACT_RUN:   state_d = run_bad ? S_EMIT : S_DCLR;
            ACT_CLEAR: state_d = S_HCLR;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_LD:   state_d = S_IDLE;
      S_DCLR: if (dclr_last) state_d = S_POP0;
      S_POP0: state_d = (heap_size_q == '0) ? S_FIN1 : S_POP1;
      S_POP1: state_d = (heap_size_q == HSW'(1)) ? S_CHK : S_POP2;
      S_POP2: state_d = S_SD0;
      S_SD0:  state_d = sd_leaf ? S_CHK : S_SD1;
      S_SD1:  state_d = sd_has_b ? S_SD2 : S_SD3;
      S_SD2:  state_d = S_SD3;
      S_SD3:  state_d = sd3_stop ? S_CHK : S_SD0;
      S_CHK:  state_d = chk_dest ? S_POP0 : S_CHK1;
      S_CHK1: state_d = chk1_stale ? S_POP0 : S_HEAD;
      S_HEAD: state_d = S_EW;
      S_EW:   state_d = ew_more ? S_ER : S_POP0;
      S_ER:   state_d = er_in ? S_RX0 : S_EW;
      S_RX0:  state_d = S_RX1;
      S_RX1:  state_d = (rx_better && !heap_full) ? S_SU0 : S_RXN;
      S_RXN:  state_d = sec_q ? S_RX0 : S_EW;
      S_SU0:  state_d = su_root ? S_RXN : S_SU1;
      S_SU1:  state_d = su1_stop ? S_RXN : S_SU0;
      S_FIN0: state_d = S_FIN1;
      S_FIN1: state_d = S_FIN2;
      S_FIN2: state_d = S_EMIT;
      S_EMIT: if (emit_ok) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d       = cnt_q;
    edge_cnt_d  = edge_cnt_q;
    heap_size_d = heap_size_q;
    node_cnt_d  = node_cnt_q;
    start_d     = start_q;
    n_d = n_q;  s_d = s_q;
    ld_from_d = ld_from_q;  ld_to_d = ld_to_q;  ld_w_d = ld_w_q;
    cur_cost_d = cur_cost_q;  cur_node_d = cur_node_q;  cur_cp_d = cur_cp_q;
    e_d = e_q;  t_d = t_q;  w_d = w_q;
    rx_cost_d = rx_cost_q;  rx_node_d = rx_node_q;  rx_cp_d = rx_cp_q;  sec_d = sec_q;
    hi_d = hi_q;  ci_d = ci_q;  ent_d = ent_q;  child_d = child_q;
    best_d = best_q;  res_d = res_q;  out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    head_we = 1'b0;  head_waddr = ld_from_q;  head_wdata = edge_cnt_q;
    head_raddr = cur_node_q;
    dist_we = 1'b0;  dist_waddr = {rx_node_q, rx_cp_q};  dist_wdata = rx_cost_q;
    dist_raddr = {rx_node_q, rx_cp_q};
    edge_we = 1'b0;  edge_waddr = edge_cnt_q[EAW-1:0];
    edge_wdata = {ld_to_q, ld_w_q, head_rdata};
    edge_raddr = e_q[EAW-1:0];
    heap_we = 1'b0;  heap_waddr = hi_q[HAW-1:0];  heap_wdata = ent_q;
    heap_raddr = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NODE_COUNT: node_cnt_d = cfg_data_i;
        CFG_START_NODE: start_d    = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_HCLR: begin
        head_we    = 1'b1;
        head_waddr = cnt_q[NIW-1:0];
        head_wdata = EMPTY_LINK;
        cnt_d      = hclr_last ? '0 : cnt_q + DAW'(1);
      end
      S_IDLE: begin
        head_raddr = from_m1[NIW-1:0];
        if (acc) begin
          case (in_data_i.action)
            ACT_LOAD: begin
              ld_from_d = from_m1[NIW-1:0];
              ld_to_d   = to_m1[NIW-1:0];
              ld_w_d    = in_data_i.edge_weight;
              res_d     = '{best_cost: '0, reachable: 1'b0, edges_full: 1'b1};
            end
            ACT_RUN: begin
              n_d   = n_clamp[NW-1:0];
              s_d   = start_m1[NIW-1:0];
              cnt_d = '0;
              res_d = '{best_cost: '0, reachable: 1'b0, edges_full: 1'b0};
            end
            ACT_CLEAR: begin
              cnt_d      = '0;
              edge_cnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_LD: begin
        // thread the new edge onto the head of its source list
        edge_we    = 1'b1;
        head_we    = 1'b1;
        edge_cnt_d = edge_cnt_q + LW'(1);
      end
      S_DCLR: begin
        dist_we    = 1'b1;
        dist_waddr = cnt_q;
        dist_wdata = (cnt_q[DAW-1:1] == s_q) ? '0 : COST_MAX;
        cnt_d      = cnt_q + DAW'(1);
        if (dclr_last) begin
          heap_we     = 1'b1;
          heap_waddr  = '0;
          heap_wdata  = {{COST_WIDTH{1'b0}}, s_q, 1'b0};
          heap_size_d = HSW'(1);
        end
      end
      S_POP0: begin
        heap_raddr = '0;
        dist_raddr = {dest, 1'b0};
      end
      S_POP1: begin
        cur_cost_d  = heap_rd_cost;
        cur_node_d  = heap_rdata[NIW:1];
        cur_cp_d    = heap_rdata[0];
        heap_size_d = heap_size_q - HSW'(1);
        heap_raddr  = HAW'(heap_size_q - HSW'(1));
      end
      S_POP2: begin
        ent_d = heap_rdata;
        hi_d  = '0;
      end
      S_SD0: begin
        heap_raddr = c_idx[HAW-1:0];
        if (sd_leaf) begin
          heap_we = 1'b1;
        end
      end
      S_SD1: begin
        child_d    = heap_rdata;
        ci_d       = c_idx[HSW-1:0];
        heap_raddr = c1_idx[HAW-1:0];
      end
      S_SD2: begin
        if (heap_rd_cost < child_cost) begin
          child_d = heap_rdata;
          ci_d    = c1_idx[HSW-1:0];
        end
      end
      S_SD3: begin
        heap_we = 1'b1;
        if (!sd3_stop) begin
          heap_wdata = child_q;
          hi_d       = ci_q;
        end
      end
      S_CHK: begin
        dist_raddr = {cur_node_q, cur_cp_q};
      end
      S_CHK1: begin
        head_raddr = cur_node_q;
      end
      S_HEAD: begin
        e_d = head_rdata;
      end
      S_EW: begin
        edge_raddr = e_q[EAW-1:0];
      end
      S_ER: begin
        e_d       = er_next;
        t_d       = er_t;
        w_d       = er_w;
        rx_cost_d = add_sat;
        rx_node_d = er_t;
        rx_cp_d   = cur_cp_q;
        sec_d     = !cur_cp_q;
      end
      S_RX0: begin
        dist_raddr = {rx_node_q, rx_cp_q};
      end
      S_RX1: begin
        if (rx_better) begin
          dist_we = 1'b1;
          if (!heap_full) begin
            ent_d       = {rx_cost_q, rx_node_q, rx_cp_q};
            hi_d        = heap_size_q;
            heap_size_d = heap_size_q + HSW'(1);
          end
        end
      end
      S_RXN: begin
        // second relax of an uncouponed state takes the halved weight
        if (sec_q) begin
          rx_cost_d = add_sat;
          rx_node_d = t_q;
          rx_cp_d   = 1'b1;
          sec_d     = 1'b0;
        end
      end
      S_SU0: begin
        heap_raddr = p_idx[HAW-1:0];
        ci_d       = p_idx;
        if (su_root) begin
          heap_we = 1'b1;
        end
      end
      S_SU1: begin
        heap_we = 1'b1;
        if (!su1_stop) begin
          heap_wdata = heap_rdata;
          hi_d       = ci_q;
        end
      end
      S_FIN0: begin
        dist_raddr = {dest, 1'b0};
      end
      S_FIN1: begin
        best_d     = dist_rdata;
        dist_raddr = {dest, 1'b1};
      end
      S_FIN2: begin
        if (fin_best < COST_MAX) begin
          res_d = '{best_cost: fin_wide[FIELD_COST_W-1:0], reachable: 1'b1, edges_full: 1'b0};
        end else begin
          res_d = '{best_cost: '0, reachable: 1'b0, edges_full: 1'b0};
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_HCLR;
      cnt_q       <= '0;
      edge_cnt_q  <= '0;
      heap_size_q <= '0;
      node_cnt_q  <= 11'd1024;
      start_q     <= 11'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      edge_cnt_q  <= edge_cnt_d;
      heap_size_q <= heap_size_d;
      node_cnt_q  <= node_cnt_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;  s_q <= s_d;
    ld_from_q <= ld_from_d;  ld_to_q <= ld_to_d;  ld_w_q <= ld_w_d;
    cur_cost_q <= cur_cost_d;  cur_node_q <= cur_node_d;  cur_cp_q <= cur_cp_d;
    e_q <= e_d;  t_q <= t_d;  w_q <= w_d;
    rx_cost_q <= rx_cost_d;  rx_node_q <= rx_node_d;  rx_cp_q <= rx_cp_d;  sec_q <= sec_d;
    hi_q <= hi_d;  ci_q <= ci_d;  ent_q <= ent_d;  child_q <= child_d;
    best_q <= best_d;  res_q <= res_d;  out_q <= out_d;
  end

  a_heap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(heap_size_q) <= HDEP)
    else $error("frontier size beyond depth");

  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edge_cnt_q) <= MAX_EDGES)
    else $error("edge count beyond store");

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LD) |=> (edge_cnt_q == $past(edge_cnt_q) + LW'(1)))
    else $error("edge load did not advance count");

endmodule
`default_nettype wire
